// ===== sv/yrp_pkg.sv =====
package yrp_pkg;

  localparam int CoefVr       = 359;
  localparam int CoefUg       = 88;
  localparam int CoefVg       = 183;
  localparam int CoefUb       = 454;
  localparam int ChromaOffset = 128;
  localparam int MaxComponent = 255;
  localparam logic [7:0] AlphaByte = 8'hff;

  localparam int NumLanes     = 2;
  localparam int PixPerLane   = 2;
  localparam int NumPix       = NumLanes * PixPerLane;

  localparam int DeltaW = 17;
  localparam int SumW   = 19;

  localparam logic [1:0] CfgIdxAlpha  = 2'd0;
  localparam logic [1:0] CfgIdxMirror = 2'd1;

  localparam logic [2:0] WordsPacked = 3'd3;
  localparam logic [2:0] WordsAlpha  = 3'd4;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic alpha_out;
    logic mirror;
  } cfg_t;

  function automatic logic [7:0] scale_clamp(input logic signed [SumW-1:0] sum);
    logic [7:0] res;
    if (sum < 0) begin
      res = 8'd0;
    end else if (sum[SumW-2:16] != '0) begin
      res = MaxComponent[7:0];
    end else begin
      res = sum[15:8];
    end
    return res;
  endfunction

endpackage

// ===== sv/yrp_lane.sv =====
module yrp_lane
  import yrp_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] group_word,
  output rgb_t        pix_a,
  output rgb_t        pix_b
);

  logic signed [8:0]        u_s;
  logic signed [8:0]        v_s;
  logic [7:0]               ya_r, ya_nxt;
  logic [7:0]               yb_r, yb_nxt;
  logic signed [DeltaW-1:0] dr_r, dr_nxt;
  logic signed [DeltaW-1:0] dg_r, dg_nxt;
  logic signed [DeltaW-1:0] db_r, db_nxt;
  logic signed [SumW-1:0]   ya_s, yb_s, dr_s, dg_s, db_s;
  rgb_t                     pix_a_r, pix_a_nxt;
  rgb_t                     pix_b_r, pix_b_nxt;

  always_comb begin
    u_s    = $signed({1'b0, group_word[23:16]}) - 9'sd128;
    v_s    = $signed({1'b0, group_word[7:0]}) - 9'sd128;
    ya_nxt = group_word[31:24];
    yb_nxt = group_word[15:8];
    dr_nxt = DeltaW'(v_s * $signed(10'(CoefVr)));
    dg_nxt = DeltaW'(u_s * $signed(10'(CoefUg))) + DeltaW'(v_s * $signed(10'(CoefVg)));
    db_nxt = DeltaW'(u_s * $signed(10'(CoefUb)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ya_r <= ya_nxt;
      yb_r <= yb_nxt;
      dr_r <= dr_nxt;
      dg_r <= dg_nxt;
      db_r <= db_nxt;
    end
  end

  always_comb begin
    ya_s = $signed({3'b000, ya_r, 8'h00});
    yb_s = $signed({3'b000, yb_r, 8'h00});
    dr_s = SumW'(dr_r);
    dg_s = SumW'(dg_r);
    db_s = SumW'(db_r);
    pix_a_nxt.r = scale_clamp(ya_s + dr_s);
    pix_a_nxt.g = scale_clamp(ya_s - dg_s);
    pix_a_nxt.b = scale_clamp(ya_s + db_s);
    pix_b_nxt.r = scale_clamp(yb_s + dr_s);
    pix_b_nxt.g = scale_clamp(yb_s - dg_s);
    pix_b_nxt.b = scale_clamp(yb_s + db_s);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_a_r <= pix_a_nxt;
      pix_b_r <= pix_b_nxt;
    end
  end

  assign pix_a = pix_a_r;
  assign pix_b = pix_b_r;

endmodule

// ===== sv/yrp_pack.sv =====
module yrp_pack
  import yrp_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  cfg_t        cfg,
  input  rgb_t        pix [NumPix],
  output logic [31:0] word0,
  output logic [31:0] word1,
  output logic [31:0] word2,
  output logic [31:0] word3,
  output logic [2:0]  word_count
);

  rgb_t        ord [NumPix];
  logic [31:0] w0_r, w0_nxt;
  logic [31:0] w1_r, w1_nxt;
  logic [31:0] w2_r, w2_nxt;
  logic [31:0] w3_r, w3_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  always_comb begin
    for (int p = 0; p < NumPix; p++) begin
      ord[p] = cfg.mirror ? pix[NumPix-1-p] : pix[p];
    end
    if (cfg.alpha_out) begin
      w0_nxt  = {AlphaByte, ord[0]};
      w1_nxt  = {AlphaByte, ord[1]};
      w2_nxt  = {AlphaByte, ord[2]};
      w3_nxt  = {AlphaByte, ord[3]};
      cnt_nxt = WordsAlpha;
    end else begin
      w0_nxt  = {ord[0], ord[1].r};
      w1_nxt  = {ord[1].g, ord[1].b, ord[2].r, ord[2].g};
      w2_nxt  = {ord[2].b, ord[3]};
      w3_nxt  = 32'h0;
      cnt_nxt = WordsPacked;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w0_r  <= w0_nxt;
      w1_r  <= w1_nxt;
      w2_r  <= w2_nxt;
      w3_r  <= w3_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign word0      = w0_r;
  assign word1      = w1_r;
  assign word2      = w2_r;
  assign word3      = w3_r;
  assign word_count = cnt_r;

endmodule

// ===== sv/yuyv_group_to_rgb_packer_top.sv =====
// Stages from input transfer to result valid: chroma products, sum and
// clamp, packing; each stage is one register.
// Throughput: one four-pixel group per cycle while not stalled by out_ready;
// two lanes convert the two group words side by side, the pack stage merges them.
// Reset (rst_n, synchronous, active low) clears the stage valid bits and
// both configuration registers; payload registers are not reset.
module yuyv_group_to_rgb_packer_top
  import yrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_group_first,
  input  logic [31:0] in_group_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word0,
  output logic [31:0] out_word1,
  output logic [31:0] out_word2,
  output logic [31:0] out_word3,
  output logic [2:0]  out_word_count
);

  cfg_t cfg_r, cfg_nxt;
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic adv;
  rgb_t pix [NumPix];

  assign adv      = !v3_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CfgIdxAlpha:  cfg_nxt.alpha_out = cfg_wdata;
        CfgIdxMirror: cfg_nxt.mirror    = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
    v1_nxt = adv ? in_valid : v1_r;
    v2_nxt = adv ? v1_r : v2_r;
    v3_nxt = adv ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      v1_r  <= v1_nxt;
      v2_r  <= v2_nxt;
      v3_r  <= v3_nxt;
    end
  end

  yrp_lane u_lane0 (
    .clk        (clk),
    .en         (adv),
    .group_word (in_group_first),
    .pix_a      (pix[0]),
    .pix_b      (pix[1])
  );

  yrp_lane u_lane1 (
    .clk        (clk),
    .en         (adv),
    .group_word (in_group_second),
    .pix_a      (pix[2]),
    .pix_b      (pix[3])
  );

  yrp_pack u_pack (
    .clk        (clk),
    .en         (adv),
    .cfg        (cfg_r),
    .pix        (pix),
    .word0      (out_word0),
    .word1      (out_word1),
    .word2      (out_word2),
    .word3      (out_word3),
    .word_count (out_word_count)
  );

  assign out_valid = v3_r;

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_count == WordsPacked || out_word_count == WordsAlpha))
    else $error("bad word count");

  a_packed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word_count == WordsPacked) |-> (out_word3 == 32'h0))
    else $error("fourth word not zero in packed mode");

  a_alpha_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word_count == WordsAlpha) |->
      (out_word0[31:24] == AlphaByte && out_word3[31:24] == AlphaByte))
    else $error("alpha byte missing");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v2_r))
    else $error("result valid without stage two item");

endmodule
